[design/wsd_pkg.sv]
// Shared types and constants for the WebSocket receive deframer.
`default_nettype none

package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CLOSED  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_PONG  = 2'd1,
        KIND_CLOSE = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] data_byte;
        logic       frame_end;
    } t_result;

endpackage

`default_nettype wire

[design/wsd_parser.sv]
// Frame header phase machine, mask key capture and payload unmasking.
`default_nettype none

module wsd_parser
    import wsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_rx_byte,
    output t_result         o_result
);

    t_phase       r_phase,     n_phase;
    logic [3:0]   r_opcode,    n_opcode;
    logic         r_masked,    n_masked;
    logic [63:0]  r_remaining, n_remaining;
    logic [2:0]   r_count,     n_count;
    logic [31:0]  r_key,       n_key;
    logic [1:0]   r_key_idx,   n_key_idx;
    logic         r_closed,    n_closed;

    logic [6:0]   w_len7;
    logic [63:0]  w_shifted;
    logic [2:0]   w_count_inc;
    logic [63:0]  w_rem_dec;
    logic         w_last;
    logic         w_len_done;
    logic         w_len_masked;
    logic         w_len_nz;
    logic         w_len_error;
    logic [7:0]   w_key_byte;

    assign w_len7      = i_rx_byte[6:0];
    assign w_shifted   = {r_remaining[55:0], i_rx_byte};
    assign w_count_inc = r_count + 3'd1;
    assign w_rem_dec   = r_remaining - {63'd0, (r_remaining != 64'd0)};
    assign w_last      = (w_rem_dec == 64'd0);

    always_comb begin
        unique case (r_key_idx)
            2'd0: w_key_byte = r_key[7:0];
            2'd1: w_key_byte = r_key[15:8];
            2'd2: w_key_byte = r_key[23:16];
            2'd3: w_key_byte = r_key[31:24];
            default: w_key_byte = 8'd0;
        endcase
    end

    // header completion decode
    always_comb begin
        w_len_done   = 1'b0;
        w_len_masked = 1'b0;
        w_len_nz     = 1'b0;
        w_len_error  = 1'b0;
        unique case (r_phase)
            PH_HDR1: begin
                w_len_done   = (w_len7 != LEN_EXT16) && (w_len7 != LEN_EXT64);
                w_len_masked = i_rx_byte[7];
                w_len_nz     = (w_len7 != 7'd0);
            end
            PH_EXT16: begin
                w_len_done   = (r_count == 3'd1);
                w_len_masked = r_masked;
                w_len_nz     = (w_shifted != 64'd0);
            end
            PH_EXT64: begin
                w_len_error  = (r_count == 3'd7) && w_shifted[63];
                w_len_done   = (r_count == 3'd7) && !w_shifted[63];
                w_len_masked = r_masked;
                w_len_nz     = (w_shifted != 64'd0);
            end
            PH_MASK: begin
                w_len_done   = (r_count == 3'd3);
                w_len_masked = 1'b0;
                w_len_nz     = (r_remaining != 64'd0);
            end
            default: begin
                w_len_done = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_masked    = r_masked;
        n_remaining = r_remaining;
        n_count     = r_count;
        n_key       = r_key;
        n_key_idx   = r_key_idx;
        n_closed    = r_closed;
        unique case (r_phase)
            PH_HDR0: begin
                n_opcode = i_rx_byte[3:0];
                n_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                n_masked = i_rx_byte[7];
                n_count  = 3'd0;
                if (w_len7 == LEN_EXT16) begin
                    n_remaining = 64'd0;
                    n_phase     = PH_EXT16;
                end else if (w_len7 == LEN_EXT64) begin
                    n_remaining = 64'd0;
                    n_phase     = PH_EXT64;
                end else begin
                    n_remaining = {57'd0, w_len7};
                end
            end
            PH_EXT16, PH_EXT64: begin
                n_remaining = w_shifted;
                n_count     = w_count_inc;
                if (w_len_done || w_len_error) begin
                    n_count = 3'd0;
                end
                if (w_len_error) begin
                    n_closed = 1'b1;
                    n_phase  = PH_CLOSED;
                end
            end
            PH_MASK: begin
                unique case (r_count[1:0])
                    2'd0: n_key[7:0]   = i_rx_byte;
                    2'd1: n_key[15:8]  = i_rx_byte;
                    2'd2: n_key[23:16] = i_rx_byte;
                    2'd3: n_key[31:24] = i_rx_byte;
                    default: n_key = r_key;
                endcase
                n_count = w_len_done ? 3'd0 : w_count_inc;
            end
            PH_PAYLOAD: begin
                n_key_idx   = r_key_idx + 2'd1;
                n_remaining = w_rem_dec;
                if (w_last) begin
                    n_phase = r_closed ? PH_CLOSED : PH_HDR0;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        if (w_len_done) begin
            if (w_len_masked) begin
                n_phase = PH_MASK;
                n_count = 3'd0;
                n_key   = 32'd0;
            end else begin
                n_key_idx = 2'd0;
                if (r_opcode == OP_CLOSE) begin
                    n_closed = 1'b1;
                    n_phase  = w_len_nz ? PH_PAYLOAD : PH_CLOSED;
                end else begin
                    n_phase  = w_len_nz ? PH_PAYLOAD : PH_HDR0;
                end
            end
        end
    end

    // result
    always_comb begin
        o_result = '{valid: 1'b0, kind: KIND_DATA, data_byte: 8'd0, frame_end: 1'b0};
        if (w_len_error) begin
            o_result.valid = 1'b1;
            o_result.kind  = KIND_ERROR;
        end else if (w_len_done && !w_len_masked) begin
            if (r_opcode == OP_CLOSE) begin
                o_result.valid = 1'b1;
                o_result.kind  = KIND_CLOSE;
            end else if (r_opcode == OP_PING) begin
                o_result.valid = 1'b1;
                o_result.kind  = KIND_PONG;
            end
        end else if (r_phase == PH_PAYLOAD && !r_closed
                     && (r_opcode == OP_BIN || r_opcode == OP_CONT)) begin
            o_result.valid     = 1'b1;
            o_result.kind      = KIND_DATA;
            o_result.data_byte = r_masked ? (i_rx_byte ^ w_key_byte) : i_rx_byte;
            o_result.frame_end = w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_opcode    <= 4'd0;
            r_masked    <= 1'b0;
            r_remaining <= 64'd0;
            r_count     <= 3'd0;
            r_key       <= 32'd0;
            r_key_idx   <= 2'd0;
            r_closed    <= 1'b0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_opcode    <= n_opcode;
            r_masked    <= n_masked;
            r_remaining <= n_remaining;
            r_count     <= n_count;
            r_key       <= n_key;
            r_key_idx   <= n_key_idx;
            r_closed    <= n_closed;
        end
    end

endmodule

`default_nettype wire

[design/wsd_out_reg.sv]
// Result register toward the downstream valid/stall channel.
`default_nettype none

module wsd_out_reg
    import wsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_result    i_result,
    input  wire logic       i_stall,
    output logic            o_free,
    output logic            o_valid,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_data_byte,
    output logic            o_frame_end
);

    logic       r_valid;
    t_kind      r_kind;
    logic [7:0] r_data_byte;
    logic       r_frame_end;

    assign o_free      = !r_valid || !i_stall;
    assign o_valid     = r_valid;
    assign o_kind      = 2'(r_kind);
    assign o_data_byte = r_data_byte;
    assign o_frame_end = r_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_result.valid;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_kind      <= i_result.kind;
            r_data_byte <= i_result.data_byte;
            r_frame_end <= i_result.frame_end;
        end
    end

endmodule

`default_nettype wire

[design/websocket_frame_deframer.sv]
// WebSocket receive deframer top level: input register, parser and result register.
// Takes one received byte per request and parses WebSocket frames: header, 16/64-bit
// length extension and mask key. Unmasked payload of binary and continuation frames
// comes out as kind 0 with frame_end on the last byte; a ping header gives kind 1,
// a close header kind 2 (after which all input is dropped until reset), and a 64-bit
// length with its top bit set gives kind 3 and closes the stream. One byte is taken
// every cycle while o_stall is low; an accepted byte is held in the input register,
// parsed out of it, and its result is loaded into the result register once that is free.
// The stream only stalls when the result register is full and the consumer stalls.
`default_nettype none

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_data_byte,
    output logic            o_frame_end
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_free;
    logic       w_step;
    t_result    w_result;

    assign w_step  = r_in_valid && w_free;
    assign o_stall = r_in_valid && !w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_free) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    wsd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_step),
        .i_rx_byte (r_in_byte),
        .o_result  (w_result)
    );

    wsd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_step),
        .i_result    (w_result),
        .i_stall     (i_stall),
        .o_free      (w_free),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_frame_end (o_frame_end)
    );

endmodule

`default_nettype wire
